/* design/mono_bitmap_color_expand_blit_unit_defines.svh */
// ----------------------------------------------------------------------------
// mono bitmap colour expansion blit unit: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef MONO_BITMAP_COLOR_EXPAND_BLIT_UNIT_DEFINES_SVH
`define MONO_BITMAP_COLOR_EXPAND_BLIT_UNIT_DEFINES_SVH

// next-cycle implication, off while in reset
`define MBCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mbce checker: property failed");

// next-cycle implication, active through reset
`define MBCE_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mbce checker: property failed");

`endif

/* design/mbce_pkg.sv */
// ----------------------------------------------------------------------------
// mbce_pkg
// types and constants of the mono bitmap colour expansion blit unit
// ----------------------------------------------------------------------------
`default_nettype none

package mbce_pkg;

  localparam int PIX_PER_BYTE  = 8;
  localparam int COL_W         = 7;
  localparam int ROW_W         = 10;
  localparam int PIXEL_ADDR_W  = 20;
  localparam int CFG_DATA_W    = 11;
  localparam int CFG_INDEX_W   = 3;
  localparam int MAX_COLS      = 128;

  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_BYTES  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_ROWS  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_DRAW_COLOR   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TRANSPARENT  = 3'd6;

  typedef struct packed {
    logic [9:0]  origin_x;
    logic [9:0]  origin_y;
    logic [7:0]  width_bytes;
    logic [10:0] height_rows;
    logic [10:0] screen_width;
    logic [7:0]  draw_color;
    logic        transparent;
  } cfg_t;

  // pixel k of a byte sits at bit k of both vectors
  typedef struct packed {
    logic [PIX_PER_BYTE-1:0] fg;
    logic [PIX_PER_BYTE-1:0] mask;
  } pix_req_t;

endpackage

`default_nettype wire

/* design/mono_bitmap_color_expand_blit_unit.sv */
// path: a taken byte passes the input register, then the pending-pixel register,
// then the pixel write register that drives the outputs
// throughput: one pixel write per cycle while out_stall is low; an opaque
// byte gives 8 writes, a transparent byte one per set bit and none if zero
// reset: synchronous, active low; clears the counters, the valid flags and
// loads the register defaults
// ----------------------------------------------------------------------------
// mono_bitmap_color_expand_blit_unit
// expands a 1 bpp bitmap, column by column, into 8-bit framebuffer writes
// ----------------------------------------------------------------------------
`default_nettype none

module mono_bitmap_color_expand_blit_unit import mbce_pkg::*; #(
  parameter int MAX_SCREEN_WIDTH = 1024,
  parameter int MAX_ROWS         = 1024,
  parameter int ADDR_BITS        = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_bitmap_byte,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [PIXEL_ADDR_W-1:0]     out_pixel_address,
  output logic [7:0]                  out_pixel_value,
  output logic                        out_last,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                 cfg_r;
  logic                 req_valid;
  logic                 req_take;
  pix_req_t             req;
  logic [ADDR_BITS-1:0] req_base;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= 10'd0;
      cfg_r.origin_y     <= 10'd0;
      cfg_r.width_bytes  <= 8'd1;
      cfg_r.height_rows  <= 11'd1;
      cfg_r.screen_width <= 11'd320;
      cfg_r.draw_color   <= 8'd15;
      cfg_r.transparent  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X:     cfg_r.origin_x     <= cfg_data[9:0];
        REG_ORIGIN_Y:     cfg_r.origin_y     <= cfg_data[9:0];
        REG_WIDTH_BYTES:  cfg_r.width_bytes  <= cfg_data[7:0];
        REG_HEIGHT_ROWS:  cfg_r.height_rows  <= cfg_data[10:0];
        REG_SCREEN_WIDTH: cfg_r.screen_width <= cfg_data[10:0];
        REG_DRAW_COLOR:   cfg_r.draw_color   <= cfg_data[7:0];
        REG_TRANSPARENT:  cfg_r.transparent  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  mbce_addr #(
    .MAX_SCREEN_WIDTH (MAX_SCREEN_WIDTH),
    .MAX_ROWS         (MAX_ROWS),
    .ADDR_BITS        (ADDR_BITS)
  ) u_addr (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_bitmap_byte (in_bitmap_byte),
    .req_valid      (req_valid),
    .req_take       (req_take),
    .req            (req),
    .req_base       (req_base)
  );

  mbce_expand #(
    .ADDR_BITS (ADDR_BITS)
  ) u_expand (
    .clk               (clk),
    .rst_n             (rst_n),
    .draw_color        (cfg_r.draw_color),
    .req_valid         (req_valid),
    .req_take          (req_take),
    .req               (req),
    .req_base          (req_base),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire

/* design/mbce_addr.sv */
// ----------------------------------------------------------------------------
// mbce_addr
// input register, bitmap position counters and base address of each byte
// ----------------------------------------------------------------------------
`default_nettype none

module mbce_addr import mbce_pkg::*; #(
  parameter int MAX_SCREEN_WIDTH = 1024,
  parameter int MAX_ROWS         = 1024,
  parameter int ADDR_BITS        = 20
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cfg_t            cfg,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      in_bitmap_byte,
  output logic                 req_valid,
  input  wire logic            req_take,
  output pix_req_t             req,
  output logic [ADDR_BITS-1:0] req_base
);

  localparam int EXT_W  = 13;
  localparam int PROD_W = 24;
  localparam int SUM_W  = 26;
  localparam int CALC_W = (ADDR_BITS > SUM_W) ? ADDR_BITS : SUM_W;
  localparam logic [EXT_W-1:0] MAX_SW_C   = EXT_W'(MAX_SCREEN_WIDTH);
  localparam logic [EXT_W-1:0] MAX_ROWS_C = EXT_W'(MAX_ROWS);
  localparam logic [7:0]       MAX_COLS_C = 8'(MAX_COLS);

  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_byte_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             accept;
  logic [EXT_W-1:0] h_ext, eff_h, row_inc, sw_ext, eff_s;
  logic [7:0]       eff_w, col_inc;
  logic [10:0]      ysum, xoff;
  logic [PROD_W-1:0] prod;
  logic [CALC_W-1:0] sum;

  assign in_stall = s1_valid_r && !req_take;
  assign accept   = in_valid && !in_stall;

  // position counters
  always_comb begin
    h_ext   = EXT_W'(cfg.height_rows);
    eff_h   = (h_ext == '0) ? EXT_W'(1) : ((h_ext > MAX_ROWS_C) ? MAX_ROWS_C : h_ext);
    eff_w   = (cfg.width_bytes == 8'd0) ? 8'd1 :
              ((cfg.width_bytes > MAX_COLS_C) ? MAX_COLS_C : cfg.width_bytes);
    row_inc = EXT_W'(row_r) + EXT_W'(1);
    col_inc = {1'b0, col_r} + 8'd1;
    row_nxt = row_r;
    col_nxt = col_r;
    if (accept) begin
      if (row_inc >= eff_h) begin
        row_nxt = '0;
        col_nxt = (col_inc >= eff_w) ? '0 : col_inc[COL_W-1:0];
      end else begin
        row_nxt = row_inc[ROW_W-1:0];
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (req_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      row_r      <= '0;
      col_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_bitmap_byte;
      s1_row_r  <= row_r;
      s1_col_r  <= col_r;
    end
  end

  // base address of the byte
  always_comb begin
    sw_ext = EXT_W'(cfg.screen_width);
    eff_s  = (sw_ext > MAX_SW_C) ? MAX_SW_C : sw_ext;
    ysum   = {1'b0, cfg.origin_y} + {1'b0, s1_row_r};
    prod   = PROD_W'(ysum) * PROD_W'(eff_s);
    xoff   = {1'b0, cfg.origin_x} + {1'b0, s1_col_r, 3'b000};
    sum    = CALC_W'(prod) + CALC_W'(xoff);
  end

  assign req_base = sum[ADDR_BITS-1:0];

  always_comb begin
    for (int k = 0; k < PIX_PER_BYTE; k++) begin
      req.fg[k] = s1_byte_r[PIX_PER_BYTE-1-k];
    end
    req.mask = cfg.transparent ? req.fg : '1;
  end

  assign req_valid = s1_valid_r;

endmodule

`default_nettype wire

/* design/mbce_expand.sv */
// ----------------------------------------------------------------------------
// mbce_expand
// walks the pending pixels of one byte and drives the pixel write register
// ----------------------------------------------------------------------------
`default_nettype none

module mbce_expand import mbce_pkg::*; #(
  parameter int ADDR_BITS = 20
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [7:0]           draw_color,
  input  wire logic                 req_valid,
  output logic                      req_take,
  input  wire pix_req_t             req,
  input  wire logic [ADDR_BITS-1:0] req_base,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output logic [PIXEL_ADDR_W-1:0]   out_pixel_address,
  output logic [7:0]                out_pixel_value,
  output logic                      out_last
);

  localparam int EXT_W = (ADDR_BITS > PIXEL_ADDR_W) ? ADDR_BITS : PIXEL_ADDR_W;

  logic                    s2_valid_r, s2_valid_nxt;
  logic [ADDR_BITS-1:0]    s2_base_r;
  logic [PIX_PER_BYTE-1:0] s2_fg_r;
  logic [PIX_PER_BYTE-1:0] s2_mask_r, s2_mask_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [PIXEL_ADDR_W-1:0] addr_r;
  logic [7:0]              value_r;
  logic                    last_r;
  logic [2:0]              sel;
  logic [PIX_PER_BYTE-1:0] rest;
  logic                    emit;
  logic [ADDR_BITS-1:0]    addr_now;
  logic [EXT_W-1:0]        addr_ext;

  // lowest pending pixel first
  always_comb begin
    sel = '0;
    for (int k = PIX_PER_BYTE - 1; k >= 0; k--) begin
      if (s2_mask_r[k]) begin
        sel = 3'(k);
      end
    end
    rest = s2_mask_r & ~(PIX_PER_BYTE'(1) << sel);
  end

  assign emit     = s2_valid_r && (!out_valid_r || !out_stall);
  assign req_take = !s2_valid_r || (emit && (rest == '0));
  assign addr_now = s2_base_r + ADDR_BITS'(sel);
  assign addr_ext = EXT_W'(addr_now);

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    s2_mask_nxt  = s2_mask_r;
    if (req_take) begin
      s2_valid_nxt = req_valid && (req.mask != '0);
      s2_mask_nxt  = req.mask;
    end else if (emit) begin
      s2_mask_nxt  = rest;
    end
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_mask_r <= s2_mask_nxt;
    if (req_take) begin
      s2_base_r <= req_base;
      s2_fg_r   <= req.fg;
    end
    if (emit) begin
      addr_r  <= addr_ext[PIXEL_ADDR_W-1:0];
      value_r <= s2_fg_r[sel] ? draw_color : 8'd0;
      last_r  <= (rest == '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_value   = value_r;
  assign out_last          = last_r;

endmodule

`default_nettype wire

/* design/mbce_checker.sv */
// ----------------------------------------------------------------------------
// mbce_checker
// port-level checks of the blit unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "mono_bitmap_color_expand_blit_unit_defines.svh"

module mbce_checker import mbce_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [PIXEL_ADDR_W-1:0] out_pixel_address,
  input wire logic [7:0]              out_pixel_value,
  input wire logic                    out_last
);

  // reset empties the write register
  `MBCE_ASSERT_NEXT_ALWAYS(a_reset_empty, !rst_n, !out_valid)

  // the rest of a byte's writes follow without a gap
  `MBCE_ASSERT_NEXT(a_burst_gapless, out_valid && !out_stall && !out_last, out_valid)

  `MBCE_ASSERT_NEXT(a_stall_holds_valid, out_valid && out_stall, out_valid)

  `MBCE_ASSERT_NEXT(a_stall_holds_data, out_valid && out_stall,
    $stable(out_pixel_address) && $stable(out_pixel_value) && $stable(out_last))

endmodule

bind mono_bitmap_color_expand_blit_unit mbce_checker u_mbce_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_pixel_address (out_pixel_address),
  .out_pixel_value   (out_pixel_value),
  .out_last          (out_last)
);

`default_nettype wire
